// ----- rtl/ethernet_ipv4_header_parser_assert.svh -----
// Assertion macros used by the header parser RTL (eip_queue).
// Uses i_clk and i_rst_n of the module that expands them.
`ifndef ETHERNET_IPV4_HEADER_PARSER_ASSERT_SVH
`define ETHERNET_IPV4_HEADER_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define EIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define EIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EIP_ASSERT(lbl, prop, msg)
`define EIP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/eip_pkg.sv -----
// Shared constants and the result record type of the header parser.
// No dependencies.
`default_nettype none
package eip_pkg;

    localparam int unsigned MaxVlanTags = 4;
    localparam int unsigned QueueDepth  = 4;
    localparam int unsigned QueueAw     = $clog2(QueueDepth);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_NOT_V4  = 3'd2;
    localparam logic [2:0] ST_OTHER   = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_TAGS    = 3'd5;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
    localparam logic [15:0] ETYPE_MPLS  = 16'h8847;
    localparam logic [15:0] ETYPE_PPPOE = 16'h8864;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_SCTP  = 8'd132;

    typedef struct packed {
        logic [2:0]  status;
        logic        vlan_present;
        logic [11:0] vlan_id;
        logic [3:0]  ip_version;
        logic [5:0]  ip_header_length;
        logic [15:0] ip_total_length;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/eip_front.sv -----
// Front end: byte-wide header parse state machine, one result record per frame.
// Depends on eip_pkg.
`default_nettype none
module eip_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_frame_end,
    output logic                  o_stall,
    input  wire logic             i_full,
    output logic                  o_push,
    output eip_pkg::t_result      o_result
);

    localparam logic [2:0] PH_ETH   = 3'd0;
    localparam logic [2:0] PH_VLAN  = 3'd1;
    localparam logic [2:0] PH_MPLS  = 3'd2;
    localparam logic [2:0] PH_PPPOE = 3'd3;
    localparam logic [2:0] PH_IPV4  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    logic [2:0]  r_phase,  n_phase;
    logic [5:0]  r_pos,    n_pos;
    logic [15:0] r_ts,     n_ts;
    logic [2:0]  r_tags,   n_tags;
    logic [11:0] r_vlan,   n_vlan;
    logic [31:0] r_hw,     n_hw;
    logic [31:0] r_src,    n_src;
    logic [31:0] r_dst,    n_dst;
    logic [2:0]  r_status, n_status;

    logic        w_accept;
    logic        w_follow;
    logic        w_from_vlan;
    logic        w_ok;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept && i_frame_end;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_ts        = r_ts;
        n_tags      = r_tags;
        n_vlan      = r_vlan;
        n_hw        = r_hw;
        n_src       = r_src;
        n_dst       = r_dst;
        n_status    = r_status;
        w_follow    = 1'b0;
        w_from_vlan = 1'b0;
        if (r_phase != PH_DONE) begin
            n_pos = r_pos + 6'd1;
            case (r_phase)
                PH_ETH: begin
                    n_ts = {r_ts[7:0], i_data_byte};
                    if ((r_pos == 6'd13 && n_ts != 16'd0) || r_pos == 6'd15) begin
                        w_follow = 1'b1;
                    end
                end
                PH_VLAN: begin
                    n_ts = {r_ts[7:0], i_data_byte};
                    if (r_pos == 6'd1) begin
                        n_vlan = n_ts[11:0];
                    end else if (r_pos == 6'd3) begin
                        w_follow    = 1'b1;
                        w_from_vlan = 1'b1;
                    end
                end
                PH_MPLS: begin
                    if (r_pos == 6'd3) begin
                        n_phase = PH_IPV4;
                        n_pos   = 6'd0;
                    end
                end
                PH_PPPOE: begin
                    if (r_pos == 6'd7) begin
                        n_phase = PH_IPV4;
                        n_pos   = 6'd0;
                    end
                end
                PH_IPV4: begin
                    if (r_pos == 6'd0) begin
                        n_hw = {i_data_byte, 24'd0};
                    end else if (r_pos == 6'd2) begin
                        n_hw[23:16] = i_data_byte;
                    end else if (r_pos == 6'd3) begin
                        n_hw[15:8] = i_data_byte;
                        if (r_hw[31:28] != 4'd4) begin
                            n_status = eip_pkg::ST_NOT_V4;
                            n_phase  = PH_DONE;
                            n_pos    = 6'd0;
                        end
                    end else if (r_pos == 6'd9) begin
                        n_hw[7:0] = i_data_byte;
                        if (i_data_byte != eip_pkg::PROTO_TCP &&
                            i_data_byte != eip_pkg::PROTO_SCTP) begin
                            n_status = eip_pkg::ST_OTHER;
                            n_phase  = PH_DONE;
                            n_pos    = 6'd0;
                        end
                    end else if (r_pos >= 6'd12 && r_pos <= 6'd15) begin
                        n_src = {r_src[23:0], i_data_byte};
                    end else if (r_pos >= 6'd16 && r_pos <= 6'd19) begin
                        n_dst = {r_dst[23:0], i_data_byte};
                        if (r_pos == 6'd19) begin
                            n_status = eip_pkg::ST_OK;
                            n_phase  = PH_DONE;
                            n_pos    = 6'd0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            if (w_follow) begin
                n_pos = 6'd0;
                if (n_ts == eip_pkg::ETYPE_IPV4) begin
                    n_phase = PH_IPV4;
                end else if (n_ts == eip_pkg::ETYPE_VLAN) begin
                    if (r_tags >= 3'(eip_pkg::MaxVlanTags)) begin
                        n_status = eip_pkg::ST_TAGS;
                        n_phase  = PH_DONE;
                    end else begin
                        n_tags  = r_tags + 3'd1;
                        n_phase = PH_VLAN;
                    end
                end else if (!w_from_vlan && n_ts == eip_pkg::ETYPE_MPLS) begin
                    n_phase = PH_MPLS;
                end else if (w_from_vlan && n_ts == eip_pkg::ETYPE_PPPOE) begin
                    n_phase = PH_PPPOE;
                end else begin
                    n_status = eip_pkg::ST_UNKNOWN;
                    n_phase  = PH_DONE;
                end
            end
        end
    end

    assign w_ok = (n_status == eip_pkg::ST_OK);

    always_comb begin
        o_result.status           = n_status;
        o_result.vlan_present     = (n_tags != 3'd0);
        o_result.vlan_id          = n_vlan;
        o_result.ip_version       = n_hw[31:28];
        o_result.ip_header_length = {n_hw[27:24], 2'b00};
        o_result.ip_total_length  = n_hw[23:8];
        o_result.ip_protocol      = w_ok ? n_hw[7:0] : 8'd0;
        o_result.source_address   = w_ok ? n_src : 32'd0;
        o_result.dest_address     = w_ok ? n_dst : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase  <= PH_ETH;
            r_pos    <= 6'd0;
            r_ts     <= 16'd0;
            r_tags   <= 3'd0;
            r_vlan   <= 12'd0;
            r_hw     <= 32'd0;
            r_src    <= 32'd0;
            r_dst    <= 32'd0;
            r_status <= eip_pkg::ST_TRUNC;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_ts     <= n_ts;
            r_tags   <= n_tags;
            r_vlan   <= n_vlan;
            r_hw     <= n_hw;
            r_src    <= n_src;
            r_dst    <= n_dst;
            r_status <= n_status;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/eip_queue.sv -----
// Short result queue between the parse front end and the output stage.
// Depends on eip_pkg and the assertion macro header.
`default_nettype none
`include "ethernet_ipv4_header_parser_assert.svh"
module eip_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire eip_pkg::t_result  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_nonempty,
    output eip_pkg::t_result       o_data
);

    localparam int unsigned Aw = eip_pkg::QueueAw;

    eip_pkg::t_result  r_mem [eip_pkg::QueueDepth];
    logic [Aw-1:0]     r_wr;
    logic [Aw-1:0]     r_rd;
    logic [Aw:0]       r_count, n_count;

    assign o_full     = (r_count == (Aw+1)'(eip_pkg::QueueDepth));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (Aw+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (Aw+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Aw'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Aw'(1);
            end
            r_count <= n_count;
        end
    end

    `EIP_ASSERT(a_no_overflow, !(i_push && o_full), "push into full result queue")
    `EIP_ASSERT(a_no_underflow, !(i_pop && !o_nonempty), "pop from empty result queue")
    `EIP_ASSERT_NEXT(a_count_track, i_push && !i_pop, r_count == $past(r_count) + (Aw+1)'(1), "queue count lost a push")

endmodule
`default_nettype wire

// ----- rtl/eip_back.sv -----
// Back end: output register that drains the result queue under downstream stall.
// Depends on eip_pkg.
`default_nettype none
module eip_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_nonempty,
    input  wire eip_pkg::t_result  i_data,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output eip_pkg::t_result       o_result
);

    logic              r_valid;
    eip_pkg::t_result  r_result;

    assign o_pop    = i_nonempty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ethernet_ipv4_header_parser.sv -----
// Ethernet/VLAN/MPLS/PPPoE to IPv4 header parser, one frame byte per cycle.
// A byte is taken every cycle; the input stalls only while the four-entry result
// queue is full, which happens only when the output side stalls across several
// short frames. Each frame yields one result record from its frame_end byte; the
// record enters the queue at that edge and moves from the queue into the output
// register once that register is free. No configuration and no clearing pass.
// Depends on eip_pkg, eip_front, eip_queue and eip_back.
`default_nettype none
module ethernet_ipv4_header_parser (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_frame_end,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [2:0]        o_status,
    output logic              o_vlan_present,
    output logic [11:0]       o_vlan_id,
    output logic [3:0]        o_ip_version,
    output logic [5:0]        o_ip_header_length,
    output logic [15:0]       o_ip_total_length,
    output logic [7:0]        o_ip_protocol,
    output logic [31:0]       o_source_address,
    output logic [31:0]       o_dest_address
);

    logic              w_full;
    logic              w_push;
    logic              w_pop;
    logic              w_nonempty;
    eip_pkg::t_result  w_front_res;
    eip_pkg::t_result  w_queue_res;
    eip_pkg::t_result  w_out_res;

    eip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_stall     (o_stall),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_result    (w_front_res)
    );

    eip_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_front_res),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_data     (w_queue_res)
    );

    eip_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_data     (w_queue_res),
        .o_pop      (w_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (w_out_res)
    );

    assign o_status           = w_out_res.status;
    assign o_vlan_present     = w_out_res.vlan_present;
    assign o_vlan_id          = w_out_res.vlan_id;
    assign o_ip_version       = w_out_res.ip_version;
    assign o_ip_header_length = w_out_res.ip_header_length;
    assign o_ip_total_length  = w_out_res.ip_total_length;
    assign o_ip_protocol      = w_out_res.ip_protocol;
    assign o_source_address   = w_out_res.source_address;
    assign o_dest_address     = w_out_res.dest_address;

endmodule
`default_nettype wire
